/* design/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_MIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_MAX = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DROP_FULL,
        OP_REMOVE_MIN,
        OP_REMOVE_MAX,
        OP_EMPTY,
        OP_CLEAR
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic exec;
        t_op  op;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

/* design/spq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels for queue commands and their results.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::CMD_W-1:0]           command;
    logic signed [spq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [spq_pkg::DATA_W-1:0]   result_value;
    logic [spq_pkg::STAT_W-1:0]          status;
    logic [spq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

/* design/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts commands, decodes them against the store
// state and holds the result register until the sink takes it.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [spq_pkg::CMD_W-1:0] i_command,
    input  logic                      i_out_ready,
    input  spq_pkg::t_dp_stat         i_stat,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output spq_pkg::t_dp_cmd          o_cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // a held result that is taken this cycle frees the output register
    assign o_in_ready  = (r_state == ST_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == ST_HOLD);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (!accept && i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.exec = accept;
        case (i_command)
            CMD_INSERT:     o_cmd.op = i_stat.full  ? OP_DROP_FULL : OP_INSERT;
            CMD_REMOVE_MIN: o_cmd.op = i_stat.empty ? OP_EMPTY     : OP_REMOVE_MIN;
            CMD_REMOVE_MAX: o_cmd.op = i_stat.empty ? OP_EMPTY     : OP_REMOVE_MAX;
            default:        o_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

/* design/spq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// Sorted store as a row of compare-and-shift cells, entry count and the
// result register.
// ----------------------------------------------------------------------------
module spq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] i_value,
    output spq_pkg::t_dp_stat                o_stat,
    output logic signed [spq_pkg::DATA_W-1:0] o_result_value,
    output logic [spq_pkg::STAT_W-1:0]       o_status,
    output logic [spq_pkg::OCC_W-1:0]        o_occupancy
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] r_entry [CAPACITY];
    logic signed [DATA_W-1:0] n_entry [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic signed [DATA_W-1:0] r_res;
    logic signed [DATA_W-1:0] n_res;
    logic [STAT_W-1:0]        r_status;
    logic [STAT_W-1:0]        n_status;
    logic [CAPACITY-1:0]      above;
    logic [IDX_W-1:0]         last_idx;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(CAPACITY));
    assign last_idx     = IDX_W'(r_count - CNT_W'(1));

    // cells past the count act as +infinity so the new value lands at the tail
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            above[i] = (CNT_W'(i) >= r_count) || (r_entry[i] > i_value);
        end
    end

    always_comb begin
        n_entry  = r_entry;
        n_count  = r_count;
        n_res    = r_res;
        n_status = r_status;
        if (i_cmd.exec) begin
            n_status = STATUS_OK;
            case (i_cmd.op)
                OP_INSERT: begin
                    n_res   = i_value;
                    n_count = r_count + CNT_W'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (above[i]) begin
                            if (i == 0) n_entry[i] = i_value;
                            else        n_entry[i] = above[i-1] ? r_entry[i-1] : i_value;
                        end
                    end
                end
                OP_DROP_FULL: begin
                    n_res    = i_value;
                    n_status = STATUS_FULL;
                end
                OP_REMOVE_MIN: begin
                    n_res   = r_entry[0];
                    n_count = r_count - CNT_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_entry[i] = r_entry[i+1];
                    end
                end
                OP_REMOVE_MAX: begin
                    n_res   = r_entry[last_idx];
                    n_count = r_count - CNT_W'(1);
                end
                OP_EMPTY: begin
                    n_res    = INT_MIN;
                    n_status = STATUS_EMPTY;
                end
                OP_CLEAR: begin
                    n_res   = '0;
                    n_count = '0;
                end
                default: begin
                    n_res = r_res;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= n_entry;
        r_res    <= n_res;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_result_value = r_res;
    assign o_status       = r_status;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

/* design/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Double-ended priority queue over a sorted store of signed 32-bit values.
// ----------------------------------------------------------------------------
//  channel   dir  port    payload
//  request   in   i_req   command[1:0], value[31:0]
//  result    out  o_rsp   result_value[31:0], status[1:0], occupancy[4:0]
//
//  A command is taken at the edge it is accepted, the store updates in the
//  same edge and its result is registered for the next cycle. The update is
//  a single compare-and-shift pass over the cell row. A new command is taken
//  while a result waits if the sink takes it that cycle. Reset clears the
//  count and the handshake; no sweep of the store.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);
    import spq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_command   (i_req.command),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    spq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_value        (i_req.value),
        .o_stat         (dp_stat),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule
